/* hw/rtl/upf_pkg.sv */
`timescale 1ns / 1ps

package upf_pkg;

    localparam int DIST_W  = 16;
    localparam int SIZE_W  = 17;
    localparam int POS_W   = 19;
    localparam int SIDES   = 4;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 32;
    localparam int IN_W    = SIDES * DIST_W;
    localparam int OUT_W   = 48;

    localparam int SIDE_FRONT = 0;
    localparam int SIDE_LEFT  = 1;
    localparam int SIDE_BACK  = 2;
    localparam int SIDE_RIGHT = 3;

    localparam logic [CIDX_W-1:0] CFG_MAX_JUMP   = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_RECOV_DIST = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_WIDTH_SUM  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_LENGTH_SUM = 8'd3;

    localparam logic [DIST_W-1:0] RST_MAX_JUMP   = 16'd640;
    localparam logic [DIST_W-1:0] RST_RECOV_DIST = 16'd320;

    typedef logic [SIDES-1:0][DIST_W-1:0] t_dist_vec;

    typedef struct packed {
        logic [DIST_W-1:0] max_jump;
        logic [DIST_W-1:0] recov_dist;
        logic [SIZE_W-1:0] width_sum;
        logic [SIZE_W-1:0] length_sum;
    } t_cfg;

    typedef struct packed {
        logic              first_pending;
        logic [SIDES-1:0]  blocked;
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x_position;
        logic signed [POS_W-1:0] y_position;
        logic [SIDES-1:0]        blocked_mask;
    } t_result;

endpackage

/* hw/rtl/upf_cfg.sv */
`timescale 1ns / 1ps

module upf_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [upf_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [upf_pkg::CDATA_W-1:0] i_cfg_data,
    output upf_pkg::t_cfg           o_cfg
);
    import upf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_JUMP:   n_cfg.max_jump   = i_cfg_data[DIST_W-1:0];
                CFG_RECOV_DIST: n_cfg.recov_dist = i_cfg_data[DIST_W-1:0];
                CFG_WIDTH_SUM:  n_cfg.width_sum  = i_cfg_data[SIZE_W-1:0];
                CFG_LENGTH_SUM: n_cfg.length_sum = i_cfg_data[SIZE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_jump   <= RST_MAX_JUMP;
            r_cfg.recov_dist <= RST_RECOV_DIST;
            r_cfg.width_sum  <= '0;
            r_cfg.length_sum <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* hw/rtl/upf_core.sv */
`timescale 1ns / 1ps

module upf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  upf_pkg::t_cfg       i_cfg,
    input  upf_pkg::t_dist_vec  i_dist,
    output upf_pkg::t_result    o_result,
    output upf_pkg::t_state     o_state
);
    import upf_pkg::*;

    t_dist_vec        r_last;
    t_state           r_state;
    t_state           n_state;
    logic [SIDES-1:0] w_toggle;
    logic [SIDES-1:0] w_flags;
    logic [SIDES-1:0] w_clear;
    t_dist_vec        w_masked;

    // distance between two unsigned values
    function automatic logic [SIZE_W-1:0] f_absdiff(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        f_absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // hi - lo, a zero side filled from the field size minus its opposite
    function automatic logic signed [POS_W-1:0] f_pair(input logic [SIZE_W-1:0] size,
                                                    input logic [DIST_W-1:0] hi,
                                                    input logic [DIST_W-1:0] lo);
        logic signed [POS_W-1:0] s_size;
        logic signed [POS_W-1:0] s_hi;
        logic signed [POS_W-1:0] s_lo;
        s_size = $signed({{(POS_W-SIZE_W){1'b0}}, size});
        s_hi   = $signed({{(POS_W-DIST_W){1'b0}}, hi});
        s_lo   = $signed({{(POS_W-DIST_W){1'b0}}, lo});
        if (hi == '0 && lo != '0) begin
            f_pair = s_size - s_lo - s_lo;
        end else if (lo == '0 && hi != '0) begin
            f_pair = s_hi + s_hi - s_size;
        end else begin
            f_pair = s_hi - s_lo;
        end
    endfunction

    always_comb begin
        for (int i = 0; i < SIDES; i++) begin
            // the first item is not compared against a previous one and never toggles
            w_toggle[i] = !r_state.first_pending &&
                (f_absdiff({1'b0, i_dist[i]}, {1'b0, r_last[i]}) >
                 {1'b0, i_cfg.max_jump});
        end
        w_clear = '0;
        if (i_cfg.width_sum != '0 &&
            f_absdiff({1'b0, i_dist[SIDE_LEFT]} + {1'b0, i_dist[SIDE_RIGHT]},
                      i_cfg.width_sum) <= {1'b0, i_cfg.recov_dist}) begin
            w_clear[SIDE_LEFT]  = 1'b1;
            w_clear[SIDE_RIGHT] = 1'b1;
        end
        if (i_cfg.length_sum != '0 &&
            f_absdiff({1'b0, i_dist[SIDE_FRONT]} + {1'b0, i_dist[SIDE_BACK]},
                      i_cfg.length_sum) <= {1'b0, i_cfg.recov_dist}) begin
            w_clear[SIDE_FRONT] = 1'b1;
            w_clear[SIDE_BACK]  = 1'b1;
        end
        w_flags = (r_state.blocked ^ w_toggle) & ~w_clear;
        for (int i = 0; i < SIDES; i++) begin
            w_masked[i] = w_flags[i] ? '0 : i_dist[i];
        end
        o_result.x_position   = f_pair(i_cfg.width_sum, w_masked[SIDE_LEFT],
                                       w_masked[SIDE_RIGHT]);
        o_result.y_position   = f_pair(i_cfg.length_sum, w_masked[SIDE_BACK],
                                       w_masked[SIDE_FRONT]);
        o_result.blocked_mask = w_flags;

        n_state.first_pending = 1'b0;
        n_state.blocked       = w_flags;
    end

    assign o_state = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.first_pending <= 1'b1;
            r_state.blocked       <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    // last distances need no reset: the first item never reads them
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_last <= i_dist;
        end
    end

endmodule

/* hw/rtl/ultrasonic_position_fusion.sv */
`timescale 1ns / 1ps

// Ultrasonic position fusion. Each input transfer carries four distances
// (front, left, back, right, 1/64 cm) and yields exactly one result transfer
// with x = left - right and y = back - front in 1/64 cm plus the blocked
// mask. A sensor's blocked flag toggles when its reading jumps by more than
// max_jump from the previous item; a pair is unblocked when its sum lies
// within recov_dist of the calibrated field size (width_sum, length_sum;
// zero disables it), and a zero side is filled from the field size minus its
// opposite. The item is held in the input register and its result in the
// result register; one item is accepted every cycle while the result
// register is empty or draining, set by the single pass from the input
// register through the fusion logic into the result register, and the
// blocked flags carried from one item to the next close within that pass.
// Configuration writes are taken every cycle and must land while idle;
// writes to an index above three are dropped.
module ultrasonic_position_fusion (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config: index 0 max_jump, 1 recov_dist, 2 width_sum, 3 length_sum
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [upf_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [upf_pkg::CDATA_W-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] front, [31:16] left, [47:32] back, [63:48] right
    input  logic [upf_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [18:0] x_position, [37:19] y_position, [41:38] blocked_mask, rest zero
    output logic [upf_pkg::OUT_W-1:0]   m_axis_tdata
);
    import upf_pkg::*;

    t_cfg      w_cfg;
    t_result   w_result;
    t_state    w_state;
    t_dist_vec r_in_data;
    logic      r_in_valid;
    t_result   r_out;
    logic      r_out_valid;
    logic      w_out_free;
    logic      w_advance;

    upf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    upf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_cfg     (w_cfg),
        .i_dist    (r_in_data),
        .o_result  (w_result),
        .o_state   (w_state)
    );

    // advance the held item whenever the result register is empty or draining
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance;
        end
    end

    // hold the result while the downstream stalls
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - 2*POS_W - SIDES){1'b0}}, r_out.blocked_mask,
                            r_out.y_position, r_out.x_position};

    // a stalled item stays in the input register untouched
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input item lost while result stalled");

    // every processed item lands in the result register
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed item produced no result");

    // the seeding pass happens once, on the first processed item
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> !w_state.first_pending)
        else $error("first item flag not cleared");

    // result mask matches the blocked state it left behind
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.blocked_mask == w_state.blocked))
        else $error("blocked mask out of step with state");

endmodule
